[design/sie_pkg.sv]
// Shared types, constants and helpers for the body step integrator.
// Used by sie_ctrl, sie_dp and semi_implicit_euler_body_step. No dependencies.
package sie_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int STEP_BITS  = 16;
    localparam int EXP_BITS   = 30;
    localparam int DIV_BITS   = 32 + FRAC_BITS;
    localparam int NORM_STEPS = 16;
    localparam int SQ_STEPS   = 16;
    localparam int NUM_ROOTS  = 16;
    localparam int CNT_W      = $clog2(DIV_BITS + 1);

    localparam logic [16:0] DAMP_ONE = 17'h10000;

    localparam logic REG_MASS = 1'b0;
    localparam logic REG_DAMP = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ADD_FORCE,
        OP_LOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_ACC_SAT,
        OP_MUL_ACC,
        OP_VEL_ADD,
        OP_NORM,
        OP_MUL_SQ,
        OP_SQ_USE,
        OP_MUL_MAG,
        OP_E_USE,
        OP_MUL_EXP,
        OP_EXP_USE,
        OP_FACTOR,
        OP_MUL_DAMP,
        OP_DAMP_USE,
        OP_MUL_POS,
        OP_POS_USE,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic             axis;
        logic [CNT_W-1:0] cnt;
    } dp_cmd_t;

    typedef struct packed {
        logic mass_zero;
    } dp_stat_t;

    typedef logic [NUM_ROOTS-1:0][EXP_BITS-1:0] root_tab_t;

    // 2^-(2^-i) in Q0.30 for i = 1..16, each a floor square root of the last
    function automatic root_tab_t calc_roots();
        root_tab_t   t;
        logic [63:0] root;
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] bit_v;
        root = 64'd1 << (EXP_BITS - 1);
        t    = '0;
        for (int i = 0; i < NUM_ROOTS; i++)
        begin
            x     = root << EXP_BITS;
            r     = 64'd0;
            bit_v = 64'd1 << 62;
            for (int j = 0; j < 32; j++)
            begin
                if (x >= r + bit_v)
                begin
                    x = x - (r + bit_v);
                    r = (r >> 1) + bit_v;
                end
                else
                begin
                    r = r >> 1;
                end
                bit_v = bit_v >> 2;
            end
            root = r;
            t[i] = root[EXP_BITS-1:0];
        end
        return t;
    endfunction

    localparam root_tab_t ROOT_TAB = calc_roots();

    function automatic logic [31:0] mag32(logic signed [31:0] a);
        return a[31] ? 32'(-a) : 32'(a);
    endfunction

    function automatic logic signed [33:0] apply_sign(logic [31:0] t, logic neg);
        logic signed [33:0] v;
        v = $signed({2'b00, t});
        return neg ? -v : v;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            return -32'sh8000_0000;
        else
            return 32'(v);
    endfunction

endpackage

[design/sie_dp.sv]
// Datapath: config registers, force/velocity state, divider, shared multiplier.
// Driven by sie_ctrl through sie_pkg::dp_cmd_t; depends on sie_pkg.
module sie_dp
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  sie_pkg::dp_cmd_t        cmd,
    output sie_pkg::dp_stat_t       stat,
    input  logic                    cfg_write,
    input  logic                    cfg_index,
    input  logic [31:0]             cfg_data,
    input  logic signed [31:0]      force_x,
    input  logic signed [31:0]      force_y,
    input  logic [15:0]             time_step,
    input  logic signed [31:0]      position_x,
    input  logic signed [31:0]      position_y,
    output logic signed [31:0]      new_x,
    output logic signed [31:0]      new_y,
    output logic signed [31:0]      speed_x,
    output logic signed [31:0]      speed_y,
    output logic                    status
);

    logic [31:0]                      mass_reg;
    logic [16:0]                      damp_reg;
    logic signed [31:0]               fsum_x_reg, fsum_y_reg;
    logic signed [31:0]               vel_x_reg, vel_y_reg;
    logic [15:0]                      step_reg;
    logic signed [31:0]               pos_x_reg, pos_y_reg;
    logic signed [31:0]               nx_reg, ny_reg;
    logic                             skip_reg;
    logic [sie_pkg::DIV_BITS-1:0]     quo_reg;
    logic [31:0]                      rem_reg;
    logic                             div_neg_reg;
    logic signed [31:0]               accel_reg;
    logic [16:0]                      m_reg;
    logic [4:0]                       k_reg;
    logic [15:0]                      frac_reg;
    logic [20:0]                      e_reg;
    logic [30:0]                      acc_reg;
    logic [63:0]                      prod_reg;
    logic                             neg_reg;
    logic signed [31:0]               out_x_reg, out_y_reg, spd_x_reg, spd_y_reg;
    logic                             status_reg;

    logic [31:0]        mul_a, mul_b;
    logic               mul_neg;
    logic signed [31:0] v_cur, p_cur, f_cur;
    logic [32:0]        rem_sh;
    logic [20:0]        mag_val;
    logic [17:0]        sq_val;
    logic [16:0]        damp_in;
    logic [3:0]         idx;

    assign v_cur   = cmd.axis ? vel_y_reg : vel_x_reg;
    assign p_cur   = cmd.axis ? pos_y_reg : pos_x_reg;
    assign f_cur   = cmd.axis ? fsum_y_reg : fsum_x_reg;
    assign rem_sh  = {rem_reg, quo_reg[sie_pkg::DIV_BITS-1]};
    assign mag_val = ({k_reg, 16'd0}) - {5'd0, frac_reg};
    assign sq_val  = prod_reg[33:16];
    assign idx     = cmd.cnt[3:0];
    assign damp_in = cfg_data[16:0];

    assign stat.mass_zero = (mass_reg == 32'd0);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a   = 32'd0;
        mul_b   = 32'd0;
        mul_neg = 1'b0;
        case (cmd.op)
            sie_pkg::OP_MUL_ACC:
            begin
                mul_a   = sie_pkg::mag32(accel_reg);
                mul_b   = {16'd0, step_reg};
                mul_neg = accel_reg[31];
            end
            sie_pkg::OP_MUL_SQ:
            begin
                mul_a = {15'd0, m_reg};
                mul_b = {15'd0, m_reg};
            end
            sie_pkg::OP_MUL_MAG:
            begin
                mul_a = {11'd0, mag_val};
                mul_b = {16'd0, step_reg};
            end
            sie_pkg::OP_MUL_EXP:
            begin
                mul_a = {1'b0, acc_reg};
                mul_b = {2'b00, sie_pkg::ROOT_TAB[idx]};
            end
            sie_pkg::OP_MUL_DAMP:
            begin
                mul_a   = sie_pkg::mag32(v_cur);
                mul_b   = {1'b0, acc_reg};
                mul_neg = v_cur[31];
            end
            sie_pkg::OP_MUL_POS:
            begin
                mul_a   = sie_pkg::mag32(v_cur);
                mul_b   = {16'd0, step_reg};
                mul_neg = v_cur[31];
            end
            default:
            begin
                mul_a = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        neg_reg  <= mul_neg;
    end

    // architectural state and config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg   <= 32'd65536;
            damp_reg   <= sie_pkg::DAMP_ONE;
            fsum_x_reg <= '0;
            fsum_y_reg <= '0;
            vel_x_reg  <= '0;
            vel_y_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == sie_pkg::REG_MASS)
                    mass_reg <= cfg_data;
                else if (damp_in == 17'd0)
                    damp_reg <= 17'd1;
                else if (damp_in > sie_pkg::DAMP_ONE)
                    damp_reg <= sie_pkg::DAMP_ONE;
                else
                    damp_reg <= damp_in;
            end
            case (cmd.op)
                sie_pkg::OP_ADD_FORCE:
                begin
                    fsum_x_reg <= sie_pkg::sat32(34'(fsum_x_reg) + 34'(force_x));
                    fsum_y_reg <= sie_pkg::sat32(34'(fsum_y_reg) + 34'(force_y));
                end
                sie_pkg::OP_VEL_ADD:
                begin
                    if (cmd.axis)
                        vel_y_reg <= sie_pkg::sat32(34'(v_cur)
                            + sie_pkg::apply_sign(prod_reg[47:16], neg_reg));
                    else
                        vel_x_reg <= sie_pkg::sat32(34'(v_cur)
                            + sie_pkg::apply_sign(prod_reg[47:16], neg_reg));
                end
                sie_pkg::OP_DAMP_USE:
                begin
                    if (cmd.axis)
                        vel_y_reg <= sie_pkg::sat32(
                            sie_pkg::apply_sign(prod_reg[61:30], neg_reg));
                    else
                        vel_x_reg <= sie_pkg::sat32(
                            sie_pkg::apply_sign(prod_reg[61:30], neg_reg));
                end
                sie_pkg::OP_RESULT:
                begin
                    if (!skip_reg)
                    begin
                        fsum_x_reg <= '0;
                        fsum_y_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            sie_pkg::OP_LOAD:
            begin
                step_reg  <= time_step;
                pos_x_reg <= position_x;
                pos_y_reg <= position_y;
                skip_reg  <= stat.mass_zero;
                m_reg     <= damp_reg;
                k_reg     <= 5'd0;
                frac_reg  <= 16'd0;
            end
            sie_pkg::OP_DIV_INIT:
            begin
                quo_reg     <= {sie_pkg::mag32(f_cur), sie_pkg::FRAC_BITS'(0)};
                rem_reg     <= 32'd0;
                div_neg_reg <= f_cur[31];
            end
            sie_pkg::OP_DIV_STEP:
            begin
                if (rem_sh >= {1'b0, mass_reg})
                begin
                    rem_reg <= 32'(rem_sh - {1'b0, mass_reg});
                    quo_reg <= {quo_reg[sie_pkg::DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[31:0];
                    quo_reg <= {quo_reg[sie_pkg::DIV_BITS-2:0], 1'b0};
                end
            end
            sie_pkg::OP_ACC_SAT:
            begin
                if (!div_neg_reg)
                    accel_reg <= (quo_reg > sie_pkg::DIV_BITS'(32'h7FFF_FFFF))
                        ? 32'sh7FFF_FFFF : $signed(quo_reg[31:0]);
                else
                    accel_reg <= (quo_reg > sie_pkg::DIV_BITS'(32'h8000_0000))
                        ? -32'sh8000_0000 : $signed(32'(-quo_reg[31:0]));
            end
            sie_pkg::OP_NORM:
            begin
                if (m_reg < sie_pkg::DAMP_ONE)
                begin
                    m_reg <= {m_reg[15:0], 1'b0};
                    k_reg <= k_reg + 5'd1;
                end
            end
            sie_pkg::OP_SQ_USE:
            begin
                if (sq_val[17])
                begin
                    m_reg    <= sq_val[17:1];
                    frac_reg <= {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_reg    <= sq_val[16:0];
                    frac_reg <= {frac_reg[14:0], 1'b0};
                end
            end
            sie_pkg::OP_E_USE:
            begin
                e_reg   <= prod_reg[36:16];
                acc_reg <= 31'd1 << sie_pkg::EXP_BITS;
            end
            sie_pkg::OP_EXP_USE:
            begin
                if (e_reg[4'd15 - idx])
                    acc_reg <= prod_reg[60:30];
            end
            sie_pkg::OP_FACTOR:
            begin
                acc_reg <= acc_reg >> e_reg[20:16];
            end
            sie_pkg::OP_POS_USE:
            begin
                if (cmd.axis)
                    ny_reg <= sie_pkg::sat32(34'(p_cur)
                        + sie_pkg::apply_sign(prod_reg[47:16], neg_reg));
                else
                    nx_reg <= sie_pkg::sat32(34'(p_cur)
                        + sie_pkg::apply_sign(prod_reg[47:16], neg_reg));
            end
            sie_pkg::OP_RESULT:
            begin
                out_x_reg  <= skip_reg ? pos_x_reg : nx_reg;
                out_y_reg  <= skip_reg ? pos_y_reg : ny_reg;
                spd_x_reg  <= vel_x_reg;
                spd_y_reg  <= vel_y_reg;
                status_reg <= skip_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign new_x   = out_x_reg;
    assign new_y   = out_y_reg;
    assign speed_x = spd_x_reg;
    assign speed_y = spd_y_reg;
    assign status  = status_reg;

endmodule

[design/sie_ctrl.sv]
// Sequencer for the body step: handshakes, iteration counts, datapath commands.
// Depends on sie_pkg; drives sie_dp.
module sie_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  sie_pkg::dp_stat_t    stat,
    output sie_pkg::dp_cmd_t     cmd
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHK, ST_DINIT, ST_DIV, ST_ASAT, ST_AMUL, ST_AUSE, ST_NORM,
        ST_SQM, ST_SQU, ST_MAGM, ST_EUSE, ST_XM, ST_XU, ST_FAC, ST_DM, ST_DU,
        ST_PM, ST_PU, ST_FIN
    } state_t;

    localparam int CW = sie_pkg::CNT_W;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            axis_reg, axis_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = sie_pkg::OP_NONE;
        cmd.axis       = axis_reg;
        cmd.cnt        = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action)
                    begin
                        cmd.op     = sie_pkg::OP_LOAD;
                        state_next = ST_CHK;
                    end
                    else
                    begin
                        cmd.op = sie_pkg::OP_ADD_FORCE;
                    end
                end
            end
            ST_CHK:
            begin
                axis_next  = 1'b0;
                state_next = stat.mass_zero ? ST_FIN : ST_DINIT;
            end
            ST_DINIT:
            begin
                cmd.op     = sie_pkg::OP_DIV_INIT;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op   = sie_pkg::OP_DIV_STEP;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(sie_pkg::DIV_BITS - 1))
                    state_next = ST_ASAT;
            end
            ST_ASAT:
            begin
                cmd.op     = sie_pkg::OP_ACC_SAT;
                state_next = ST_AMUL;
            end
            ST_AMUL:
            begin
                cmd.op     = sie_pkg::OP_MUL_ACC;
                state_next = ST_AUSE;
            end
            ST_AUSE:
            begin
                cmd.op   = sie_pkg::OP_VEL_ADD;
                cnt_next = '0;
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = ST_DINIT;
                end
                else
                begin
                    axis_next  = 1'b0;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                cmd.op   = sie_pkg::OP_NORM;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(sie_pkg::NORM_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_SQM;
                end
            end
            ST_SQM:
            begin
                cmd.op     = sie_pkg::OP_MUL_SQ;
                state_next = ST_SQU;
            end
            ST_SQU:
            begin
                cmd.op   = sie_pkg::OP_SQ_USE;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(sie_pkg::SQ_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_MAGM;
                end
                else
                begin
                    state_next = ST_SQM;
                end
            end
            ST_MAGM:
            begin
                cmd.op     = sie_pkg::OP_MUL_MAG;
                state_next = ST_EUSE;
            end
            ST_EUSE:
            begin
                cmd.op     = sie_pkg::OP_E_USE;
                cnt_next   = '0;
                state_next = ST_XM;
            end
            ST_XM:
            begin
                cmd.op     = sie_pkg::OP_MUL_EXP;
                state_next = ST_XU;
            end
            ST_XU:
            begin
                cmd.op   = sie_pkg::OP_EXP_USE;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(sie_pkg::NUM_ROOTS - 1))
                    state_next = ST_FAC;
                else
                    state_next = ST_XM;
            end
            ST_FAC:
            begin
                cmd.op     = sie_pkg::OP_FACTOR;
                axis_next  = 1'b0;
                state_next = ST_DM;
            end
            ST_DM:
            begin
                cmd.op     = sie_pkg::OP_MUL_DAMP;
                state_next = ST_DU;
            end
            ST_DU:
            begin
                cmd.op     = sie_pkg::OP_DAMP_USE;
                state_next = ST_PM;
            end
            ST_PM:
            begin
                cmd.op     = sie_pkg::OP_MUL_POS;
                state_next = ST_PU;
            end
            ST_PU:
            begin
                cmd.op = sie_pkg::OP_POS_USE;
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = ST_DM;
                end
                else
                begin
                    axis_next  = 1'b0;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.op         = sie_pkg::OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[design/semi_implicit_euler_body_step.sv]
// Top level of the 2D body integrator: controller plus datapath.
// Depends on sie_pkg, sie_ctrl and sie_dp.
//
// One body, Q16.16 fixed point. An add-force item (action 0) is taken while
// idle and adds its force into a saturating accumulator; it gives no result.
// A tick item (action 1) runs two 48-step restoring divisions (force / mass,
// one bit a cycle), 16 normalize steps and 16 squaring steps for log2 of the
// damping, 16 exp2 steps, then damping and position updates, all multiplies
// going through one shared 32x32 multiplier with a registered product. A tick
// with zero mass reports status 1 with the state untouched. The result sits
// in an output register; the next item is taken while it waits, but a later
// tick holds at its end until that slot is free. Config writes (index 0 mass,
// index 1 damping, clamped to 1..65536) are meant to land while the block is
// idle.
module semi_implicit_euler_body_step
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    input  logic signed [31:0]  force_x,
    input  logic signed [31:0]  force_y,
    input  logic [15:0]         time_step,
    input  logic signed [31:0]  position_x,
    input  logic signed [31:0]  position_y,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  new_x,
    output logic signed [31:0]  new_y,
    output logic signed [31:0]  speed_x,
    output logic signed [31:0]  speed_y,
    output logic                status,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);

    sie_pkg::dp_cmd_t  cmd;
    sie_pkg::dp_stat_t stat;

    sie_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    sie_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .force_x    (force_x),
        .force_y    (force_y),
        .time_step  (time_step),
        .position_x (position_x),
        .position_y (position_y),
        .new_x      (new_x),
        .new_y      (new_y),
        .speed_x    (speed_x),
        .speed_y    (speed_y),
        .status     (status)
    );

endmodule
